// ===== rtl/core/ihc_pkg.sv =====
// ----------------------------------------------------------------------------
// ihc_pkg
// shared types, constants and helpers for the ipv4 header checker
// ----------------------------------------------------------------------------
package ihc_pkg;

  // verdict codes carried on the result word
  typedef enum logic [2:0] {
    VERDICT_ACCEPT   = 3'd0,
    VERDICT_VERSION  = 3'd1,
    VERDICT_HEADLEN  = 3'd2,
    VERDICT_TTL      = 3'd3,
    VERDICT_CHECKSUM = 3'd4,
    VERDICT_DEST     = 3'd5
  } verdict_e;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [3:0]  IP_VERSION     = 4'd4;
  localparam logic [3:0]  MIN_IHL        = 4'd5;
  localparam logic [5:0]  IDX_TTL        = 6'd8;
  localparam logic [5:0]  IDX_CHECKSUM   = 6'd11;
  localparam logic [5:0]  IDX_DEST_FIRST = 6'd16;
  localparam logic [5:0]  IDX_DEST_LAST  = 6'd19;
  localparam logic [31:0] BROADCAST_ADDR = 32'hffff_ffff;

  // one decided packet handed from front to back
  typedef struct packed {
    logic        early;     // verdict already known from byte 0
    verdict_e    code;      // early verdict
    logic        ttl_zero;
    logic [20:0] sum;       // plain sum of header words, checksum word left out
    logic [15:0] chk;       // stored checksum field
    logic [31:0] dest;      // destination address field
  } job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // end-around fold of the 21-bit sum, then one's complement
  function automatic logic [15:0] fold_complement(input logic [20:0] s);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {12'd0, s[20:16]} + {1'b0, s[15:0]};
    s2 = {16'd0, s1[16]} + {1'b0, s1[15:0]};
    return ~s2[15:0];
  endfunction

endpackage

// ===== rtl/core/ihc_front.sv =====
// ----------------------------------------------------------------------------
// ihc_front
// byte-serial header parser: gathers fields and the running sum, pushes jobs
// ----------------------------------------------------------------------------
module ihc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,      // byte word accepted this cycle
  input  logic [7:0]        byte_i,
  input  logic              start_i,
  output logic              push_o,
  output ihc_pkg::job_t     job_o
);

  logic [5:0]  byte_cnt_q, byte_cnt_d;
  logic [3:0]  hdr_words_q, hdr_words_d;
  logic [20:0] word_sum_q, word_sum_d;
  logic [7:0]  hi_byte_q, hi_byte_d;
  logic [15:0] stored_chk_q, stored_chk_d;
  logic [31:0] dest_q, dest_d;
  logic        ttl_zero_q, ttl_zero_d;
  logic        done_q, done_d;

  logic [15:0] word;
  logic [6:0]  idx_next;

  always_comb begin
    byte_cnt_d   = byte_cnt_q;
    hdr_words_d  = hdr_words_q;
    word_sum_d   = word_sum_q;
    hi_byte_d    = hi_byte_q;
    stored_chk_d = stored_chk_q;
    dest_d       = dest_q;
    ttl_zero_d   = ttl_zero_q;
    done_d       = done_q;
    push_o       = 1'b0;
    job_o        = '0;
    word         = '0;
    idx_next     = '0;

    if (take_i && (start_i || !done_q)) begin
      if (start_i) begin
        byte_cnt_d   = '0;
        word_sum_d   = '0;
        hi_byte_d    = '0;
        stored_chk_d = '0;
        dest_d       = '0;
        ttl_zero_d   = 1'b0;
        hdr_words_d  = byte_i[3:0];
        done_d       = 1'b0;
      end

      if (start_i && byte_i[7:4] != ihc_pkg::IP_VERSION) begin
        push_o     = 1'b1;
        job_o.early = 1'b1;
        job_o.code = ihc_pkg::VERDICT_VERSION;
        done_d     = 1'b1;
      end else if (start_i && byte_i[3:0] < ihc_pkg::MIN_IHL) begin
        push_o     = 1'b1;
        job_o.early = 1'b1;
        job_o.code = ihc_pkg::VERDICT_HEADLEN;
        done_d     = 1'b1;
      end else begin
        // byte_cnt_d, word_sum_d etc. hold the start-adjusted values here
        word = {hi_byte_d, byte_i};
        if (!byte_cnt_d[0]) begin
          hi_byte_d = byte_i;
        end else if (byte_cnt_d == ihc_pkg::IDX_CHECKSUM) begin
          stored_chk_d = word;
        end else begin
          word_sum_d = word_sum_d + {5'd0, word};
        end
        if (byte_cnt_d == ihc_pkg::IDX_TTL) begin
          ttl_zero_d = (byte_i == 8'd0);
        end
        if (byte_cnt_d >= ihc_pkg::IDX_DEST_FIRST && byte_cnt_d <= ihc_pkg::IDX_DEST_LAST) begin
          dest_d = {dest_d[23:0], byte_i};
        end
        idx_next   = {1'b0, byte_cnt_d} + 7'd1;
        byte_cnt_d = idx_next[5:0];

        // last header byte: hand the gathered header to the back end
        if (idx_next == {1'b0, hdr_words_d, 2'b00}) begin
          push_o         = 1'b1;
          job_o.early    = 1'b0;
          job_o.code     = ihc_pkg::VERDICT_ACCEPT;
          job_o.ttl_zero = ttl_zero_d;
          job_o.sum      = word_sum_d;
          job_o.chk      = stored_chk_d;
          job_o.dest     = dest_d;
          done_d         = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q   <= '0;
      hdr_words_q  <= '0;
      word_sum_q   <= '0;
      hi_byte_q    <= '0;
      stored_chk_q <= '0;
      dest_q       <= '0;
      ttl_zero_q   <= 1'b0;
      done_q       <= 1'b1;
    end else begin
      byte_cnt_q   <= byte_cnt_d;
      hdr_words_q  <= hdr_words_d;
      word_sum_q   <= word_sum_d;
      hi_byte_q    <= hi_byte_d;
      stored_chk_q <= stored_chk_d;
      dest_q       <= dest_d;
      ttl_zero_q   <= ttl_zero_d;
      done_q       <= done_d;
    end
  end

endmodule

// ===== rtl/core/ihc_queue.sv =====
// ----------------------------------------------------------------------------
// ihc_queue
// short job queue between parser and verdict stage
// ----------------------------------------------------------------------------
module ihc_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ihc_pkg::job_t       job_i,
  input  logic                pop_i,
  output ihc_pkg::job_t       head_o,
  output ihc_pkg::q_status_t  status_o
);

  ihc_pkg::job_t entries_q [ihc_pkg::QDEPTH];

  logic [ihc_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [ihc_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [ihc_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  localparam logic [ihc_pkg::QPTR_W-1:0] PTR_LAST = ihc_pkg::QPTR_W'(ihc_pkg::QDEPTH - 1);
  localparam logic [ihc_pkg::QCNT_W-1:0] CNT_FULL = ihc_pkg::QCNT_W'(ihc_pkg::QDEPTH);

  assign status_o.full  = (cnt_q == CNT_FULL);
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // no overflow, no underflow
  assert property (@(posedge clk_i) disable iff (!rst_ni) status_o.full |-> !push_i || pop_i)
    else $error("ihc_queue: push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) status_o.empty |-> !pop_i)
    else $error("ihc_queue: pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push_i && !pop_i) |=> !status_o.empty)
    else $error("ihc_queue: pushed job lost");

endmodule

// ===== rtl/core/ihc_back.sv =====
// ----------------------------------------------------------------------------
// ihc_back
// verdict stage: passes on early verdicts, else checks ttl, checksum and destination; holds the result word
// ----------------------------------------------------------------------------
module ihc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ihc_pkg::job_t       head_i,
  input  ihc_pkg::q_status_t  status_i,
  input  logic [31:0]         own_addr_i,
  output logic                pop_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output ihc_pkg::verdict_e   verdict_o,
  output logic                accept_o
);

  logic              out_valid_q, out_valid_d;
  ihc_pkg::verdict_e verdict_q, verdict_d;
  logic              accept_q;

  assign pop_o = !status_i.empty && (!out_valid_q || out_ready_i);

  always_comb begin
    if (head_i.early) begin
      verdict_d = head_i.code;
    end else if (head_i.ttl_zero) begin
      verdict_d = ihc_pkg::VERDICT_TTL;
    end else if (ihc_pkg::fold_complement(head_i.sum) != head_i.chk) begin
      verdict_d = ihc_pkg::VERDICT_CHECKSUM;
    end else if (head_i.dest != own_addr_i && head_i.dest != ihc_pkg::BROADCAST_ADDR) begin
      verdict_d = ihc_pkg::VERDICT_DEST;
    end else begin
      verdict_d = ihc_pkg::VERDICT_ACCEPT;
    end
    out_valid_d = pop_o || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      verdict_q <= verdict_d;
      accept_q  <= (verdict_d == ihc_pkg::VERDICT_ACCEPT);
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign accept_o    = accept_q;

  // a held result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !out_ready_i) |-> !pop_o)
    else $error("ihc_back: result overwritten while stalled");

endmodule

// ===== rtl/core/ipv4_header_check_top.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_check_top
// byte-serial ipv4 header checker with one verdict word per packet
// ----------------------------------------------------------------------------
// input stream carries one packet byte per word, tuser high on the first byte
// output stream carries one verdict word per packet: code in tdata, accept flag
// in tuser; config channel writes this host's address, register resets to zero
// one byte word per clock while a queue slot is free: the front parser
// touches each byte once, its 21-bit running sum the only loop between bytes
// a version or header length error is decided on byte 0, all other verdicts
// on the last header byte; the verdict word then goes through the job queue
// and the verdict register, which drives the output
// bytes after the header, and bytes with no packet open, give no word
// a new start before the verdict drops the open packet silently
// when the receiver stalls, the verdict register holds and the two-entry queue
// keeps filling; input ready drops only once both entries are taken
// after reset the block is idle, waiting for a start byte
// ----------------------------------------------------------------------------
module ipv4_header_check_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] packet_start
  // verdict stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [2:0] verdict, [7:3] zero
  output logic        m_axis_tuser,   // [0] accept
  // own address write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] own_addr_q, own_addr_d;

  logic               take;
  logic               push;
  logic               pop;
  ihc_pkg::job_t      job;
  ihc_pkg::job_t      head;
  ihc_pkg::q_status_t q_status;
  ihc_pkg::verdict_e  verdict;

  // config register, always ready
  assign cfg_ready_o = 1'b1;
  assign own_addr_d  = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : own_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= '0;
    end else begin
      own_addr_q <= own_addr_d;
    end
  end

  // front takes a byte whenever a queue slot is free
  assign s_axis_tready = !q_status.full;
  assign take          = s_axis_tvalid && s_axis_tready;

  ihc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .byte_i  (s_axis_tdata),
    .start_i (s_axis_tuser),
    .push_o  (push),
    .job_o   (job)
  );

  ihc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  ihc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (q_status),
    .own_addr_i  (own_addr_q),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .verdict_o   (verdict),
    .accept_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {5'd0, verdict};

endmodule

// ===== bench/ihc_verdict_checker.sv =====
// ----------------------------------------------------------------------------
// ihc_verdict_checker
// watches the byte, verdict and address channels of the ipv4 header checker,
// predicts the verdict word of each packet and compares it on arrival
// ----------------------------------------------------------------------------
module ihc_verdict_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] packet_start
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,   // [2:0] verdict, [7:3] zero
  input  logic        m_axis_tuser,   // [0] accept
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  // shadow of the header parser
  logic [31:0] own_ip;
  logic [5:0]  hdr_idx;
  logic [3:0]  ihl_words;
  logic [20:0] sum21;
  logic [7:0]  hi_byte;
  logic [15:0] csum_field;
  logic [31:0] dst_addr;
  logic        ttl_is_zero;
  logic        pkt_open;

  ihc_pkg::verdict_e verdict_q[$];
  int unsigned       mismatch_cnt;

  function automatic logic [15:0] ones_fold(input logic [20:0] s);
    int unsigned t;
    t = s[15:0] + s[20:16];
    t = (t & 32'hffff) + (t >> 16);
    return ~t[15:0];
  endfunction

  // returns 1 when this byte closes the packet with a verdict
  function automatic logic predict_verdict(input logic [7:0] b, input logic first,
                                           output ihc_pkg::verdict_e code);
    logic [5:0] idx;
    code = ihc_pkg::VERDICT_ACCEPT;
    if (first) begin
      hdr_idx     = '0;
      sum21       = '0;
      hi_byte     = '0;
      csum_field  = '0;
      dst_addr    = '0;
      ttl_is_zero = 1'b0;
      ihl_words   = b[3:0];
      pkt_open    = 1'b1;
      if (b[7:4] != ihc_pkg::IP_VERSION) begin
        pkt_open = 1'b0;
        code     = ihc_pkg::VERDICT_VERSION;
        return 1'b1;
      end
      if (b[3:0] < ihc_pkg::MIN_IHL) begin
        pkt_open = 1'b0;
        code     = ihc_pkg::VERDICT_HEADLEN;
        return 1'b1;
      end
    end else if (!pkt_open) begin
      return 1'b0;
    end

    idx = hdr_idx;
    if (!idx[0]) begin
      hi_byte = b;
    end else if (idx == ihc_pkg::IDX_CHECKSUM) begin
      csum_field = {hi_byte, b};
    end else begin
      sum21 = sum21 + {5'd0, hi_byte, b};
    end
    if (idx == ihc_pkg::IDX_TTL) ttl_is_zero = (b == 8'd0);
    if (idx >= ihc_pkg::IDX_DEST_FIRST && idx <= ihc_pkg::IDX_DEST_LAST) begin
      dst_addr = {dst_addr[23:0], b};
    end
    hdr_idx = idx + 6'd1;

    if (int'(idx) + 1 != 4 * int'(ihl_words)) return 1'b0;

    pkt_open = 1'b0;
    if (ttl_is_zero) begin
      code = ihc_pkg::VERDICT_TTL;
    end else if (ones_fold(sum21) != csum_field) begin
      code = ihc_pkg::VERDICT_CHECKSUM;
    end else if (dst_addr != own_ip && dst_addr != ihc_pkg::BROADCAST_ADDR) begin
      code = ihc_pkg::VERDICT_DEST;
    end
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ihc_pkg::verdict_e code;
    ihc_pkg::verdict_e want;
    if (!rst_ni) begin
      own_ip       = '0;
      hdr_idx      = '0;
      ihl_words    = '0;
      sum21        = '0;
      hi_byte      = '0;
      csum_field   = '0;
      dst_addr     = '0;
      ttl_is_zero  = 1'b0;
      pkt_open     = 1'b0;
      mismatch_cnt = 0;
      verdict_q.delete();
      errors_o    <= 0;
      pending_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) own_ip = cfg_data_i;

      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch($sformatf("verdict word with none expected: tdata 0x%02h tuser %b",
                                  m_axis_tdata, m_axis_tuser));
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata !== {5'd0, want} ||
              m_axis_tuser !== (want == ihc_pkg::VERDICT_ACCEPT))
            flag_mismatch($sformatf(
              "verdict mismatch: expected code %0d accept %b, got tdata 0x%02h tuser %b",
              want, want == ihc_pkg::VERDICT_ACCEPT, m_axis_tdata, m_axis_tuser));
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (predict_verdict(s_axis_tdata, s_axis_tuser, code)) verdict_q.push_back(code);
      end

      errors_o  <= mismatch_cnt;
      pending_o <= verdict_q.size();
    end
  end

endmodule

// ===== bench/ipv4_header_check_top_tb.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_check_top_tb
// drives byte-serial ipv4 packets into the header checker under changing
// handshake pressure and address settings; a side checker predicts each
// verdict word and this top reports the outcome
// ----------------------------------------------------------------------------
module ipv4_header_check_top_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef logic [7:0] hdr_bytes_t [60];

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i    = 32'd0;

  int unsigned chk_errors;
  int unsigned verdicts_pending;

  // stimulus bookkeeping
  int unsigned tx_idle_pct = 21;
  int unsigned rx_idle_pct = 48;
  int unsigned phase       = 0;
  int unsigned words_sent  = 0;   // byte words taken by the block
  int unsigned cycle_cnt   = 0;
  logic        hold_off    = 1'b0;
  logic [31:0] own_ip_tb   = 32'd0;

  ipv4_header_check_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // predicts and compares every verdict word
  ihc_verdict_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (chk_errors),
    .pending_o     (verdicts_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, or a solid stall while hold_off is up
  always @(posedge clk_i) begin
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long receiver stall at the start of the last phase, while the sender keeps
  // pushing short packets: the two-entry queue and the verdict register fill up
  // and the block has to drop its input ready
  initial begin
    wait (phase == 3);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // checksum of a header as the sender has to fill it in: end-around sum of
  // all 16-bit words except the checksum word itself, then complemented
  function automatic logic [15:0] header_checksum(input hdr_bytes_t h, input int unsigned ihl);
    int unsigned acc;
    acc = 0;
    for (int i = 0; i < 2 * ihl; i++) begin
      if (i != 5) acc += {h[2*i], h[2*i+1]};
    end
    while ((acc >> 16) != 0) acc = (acc & 32'hffff) + (acc >> 16);
    return ~acc[15:0];
  endfunction

  // one byte word, with random sender gaps ahead of it
  task automatic send_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // address writes only once the block has nothing left to say
  task automatic write_own_address(input logic [31:0] addr);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (verdicts_pending != 0);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= addr;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    own_ip_tb = addr;
  endtask

  // one random packet: early error, stray bytes, a cut-off header, or a full
  // header (mostly well formed) with some trailing payload
  task automatic send_packet();
    hdr_bytes_t  hdr;
    int unsigned kind;
    int unsigned ihl;
    int unsigned cut;
    int unsigned npay;
    int unsigned pick;
    int unsigned ver;
    logic [31:0] dst;
    logic [15:0] csum;
    kind = $urandom_range(99);

    if (kind < 10) begin
      // decided on byte 0: either a wrong version or a too-short header
      if ($urandom_range(1) == 1) begin
        hdr[0] = {ihc_pkg::IP_VERSION, 4'($urandom_range(4))};
      end else begin
        ver = $urandom_range(14);
        if (ver >= 4) ver++;
        hdr[0] = {4'(ver), 4'($urandom_range(15))};
      end
      send_byte(hdr[0], 1'b1);
      return;
    end

    if (kind < 15) begin
      // stray bytes with no start mark
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)), 1'b0);
      return;
    end

    ihl = ($urandom_range(99) < 70) ? 5 : $urandom_range(6, 15);
    for (int i = 0; i < 4 * ihl; i++) hdr[i] = 8'($urandom_range(255));
    hdr[0] = {ihc_pkg::IP_VERSION, 4'(ihl)};

    // ttl zero now and then, otherwise forced nonzero
    if ($urandom_range(99) < 8) begin
      hdr[8] = 8'd0;
    end else if (hdr[8] == 8'd0) begin
      hdr[8] = 8'd1;
    end

    pick = $urandom_range(99);
    if (pick < 40) begin
      dst = own_ip_tb;
    end else if (pick < 65) begin
      dst = ihc_pkg::BROADCAST_ADDR;
    end else begin
      dst = $urandom;
    end
    {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;

    csum = header_checksum(hdr, ihl);
    if ($urandom_range(99) < 10) csum ^= 16'(1 << $urandom_range(15));
    {hdr[10], hdr[11]} = csum;

    // a cut-off header is abandoned by whatever start comes next
    cut = (kind < 20) ? $urandom_range(1, 4 * ihl - 1) : 4 * ihl;
    for (int i = 0; i < cut; i++) send_byte(hdr[i], i == 0);

    if (kind >= 20) begin
      npay = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(4);
      repeat (npay) send_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  initial begin
    hdr_bytes_t  hdr;
    logic [15:0] csum;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_own_address($urandom);
    tx_idle_pct = 21;
    rx_idle_pct = 48;
    phase       = 1;

    // directed: byte-0 errors at the field extremes, a stray byte while idle
    send_byte(8'h00, 1'b1);   // version 0
    send_byte(8'hff, 1'b1);   // version 15, ihl 15
    send_byte(8'h44, 1'b1);   // header length one short
    send_byte(8'h40, 1'b1);   // header length zero
    send_byte(8'hff, 1'b0);   // nothing open, must be ignored

    // directed: minimal well-formed header to the broadcast address
    for (int i = 0; i < 20; i++) hdr[i] = 8'h00;
    hdr[0] = {ihc_pkg::IP_VERSION, ihc_pkg::MIN_IHL};
    hdr[3] = 8'd20;
    hdr[8] = 8'hff;
    hdr[9] = 8'h11;
    {hdr[12], hdr[13], hdr[14], hdr[15]} = 32'hc0a8_0001;
    {hdr[16], hdr[17], hdr[18], hdr[19]} = ihc_pkg::BROADCAST_ADDR;
    csum = header_checksum(hdr, 5);
    {hdr[10], hdr[11]} = csum;
    for (int i = 0; i < 20; i++) send_byte(hdr[i], i == 0);

    // phase 1: sender idles a little, receiver a lot
    while (words_sent < 330) send_packet();

    // phase 2: the other way round, address at its low extreme
    write_own_address(32'h0000_0000);
    tx_idle_pct = 48;
    rx_idle_pct = 21;
    phase       = 2;
    while (words_sent < 640) send_packet();

    // phase 3: no idling, address at its high extreme; opens with a burst of
    // one-byte packets into the long receiver stall
    write_own_address(32'hffff_ffff);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    phase       = 3;
    repeat (12) begin
      send_byte({4'h6, 4'($urandom_range(15))}, 1'b1);
    end
    while (words_sent < 950) send_packet();

    // drain
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (verdicts_pending != 0);
    repeat (10) @(posedge clk_i);

    if (chk_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ihc_pkg.sv
rtl/core/ihc_front.sv
rtl/core/ihc_queue.sv
rtl/core/ihc_back.sv
rtl/core/ipv4_header_check_top.sv
bench/ihc_verdict_checker.sv
bench/ipv4_header_check_top_tb.sv
